// ===== hdl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types, register indexes, reset values and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_MODE = 2'd2;

	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

	localparam logic [7:0] MAG_CLAMP = 8'd255;

	typedef struct packed {
		logic       mode;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] edge_red;
		logic [7:0] edge_green;
		logic [7:0] edge_blue;
		logic       last;
		logic       frame_end;
	} result_t;

	// one color channel on its way through the root chain
	typedef struct packed {
		logic        sat;
		logic [15:0] rad;
		logic [7:0]  root;
		logic [7:0]  l1;
	} sq_chan_t;

	typedef struct packed {
		sq_chan_t [2:0] ch;
		logic           mode;
		logic           last;
		logic           fend;
	} sq_beat_t;

	typedef struct packed {
		logic [2:0][9:0] ax;
		logic [2:0][9:0] ay;
		logic            mode;
		logic            last;
		logic            fend;
	} grad_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_EMIT1,
		S_EMIT2
	} seq_state_t;

	function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	// weighted sum of three 8-bit taps: a + 2b + c
	function automatic logic [9:0] tap_sum(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		tap_sum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sobel_edge_magnitude_rgb_top.sv =====
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// 3x3 Sobel gradient magnitude per color channel over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel beats enter on pixel/pixel_valid, the block holds pixel_stall high
//   while it works on the current beat. Each pixel beat (mode 0) carries one
//   RGB pixel in raster order; after the last row send one drain beat
//   (mode 1) per column to flush it. Beats that do not fit the frame state
//   (pixel while waiting for drain, drain before the frame is complete) are
//   dropped with no effect.
//   Results leave on result/result_valid; the receiver holds result_stall to
//   stop them. A stall freezes the whole root chain and the output register.
//   Output lags input by one row and one column; a beat at the last column
//   gives two results, last marks the final result of a beat.
//   The single window update sequencer takes each beat through LOAD, EMIT1
//   and, at the last column of a row, EMIT2, and takes no new beat before
//   it is back in IDLE; a result push waits on a stalled output register.
//   Path from acceptance to the first result: line store read, window load,
//   gradient stage, square stage, eight root cells, output register; a sole
//   right edge result at column 0 is pushed from EMIT2, after EMIT1.
//   Configuration writes on cfg_valid/cfg_ready are always taken; write them
//   only while the block is idle.
//   Reset clears counters, window and all valid bits; the line stores are
//   not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_rgb_top
	import sem_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pixel_valid,
	output logic                       pixel_stall,
	input  wire pixel_t                pixel,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW   = $clog2(MAX_HEIGHT + 1);
	localparam int CMPW = 17;
	localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
	localparam logic [CMPW-1:0] MAXH_C = CMPW'(MAX_HEIGHT);

	// configuration registers
	logic [11:0] fw_q;
	logic [12:0] fh_q;
	logic        mm_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
			mm_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:    fw_q <= cfg_data[11:0];
				CFG_FRAME_HEIGHT:   fh_q <= cfg_data;
				CFG_MAGNITUDE_MODE: mm_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective frame size: zero acts as one, clamp to MAX_WIDTH/MAX_HEIGHT
	logic [CMPW-1:0] w_eff, h_eff;

	always_comb begin
		w_eff = CMPW'(fw_q);
		if (w_eff == '0) w_eff = CMPW'(1);
		if (w_eff > MAXW_C) w_eff = MAXW_C;
		h_eff = CMPW'(fh_q);
		if (h_eff == '0) h_eff = CMPW'(1);
		if (h_eff > MAXH_C) h_eff = MAXH_C;
	end

	// frame position
	logic [AW-1:0] col_q, drn_q;
	logic [RW-1:0] row_q;

	seq_state_t state_q, state_nxt;

	logic          awaiting, take, cur_drain, cur_last;
	logic [AW-1:0] cur_c;

	assign awaiting  = CMPW'(row_q) >= h_eff;
	assign cur_drain = pixel.mode;
	assign cur_c     = cur_drain ? drn_q : col_q;
	assign cur_last  = CMPW'(cur_c) >= (w_eff - CMPW'(1));
	assign take      = pixel_valid && !pixel_stall && (cur_drain == awaiting);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			drn_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (cur_drain) begin
				if (cur_last) begin
					drn_q <= '0;
					col_q <= '0;
					row_q <= '0;
				end else begin
					drn_q <= drn_q + AW'(1);
				end
			end else begin
				if (cur_last) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// hold the accepted beat for the window update
	logic          drain_q, last_col_q, produce_q, top_mid_q;
	logic [AW-1:0] c_q;
	logic [23:0]   px_q;

	always_ff @(posedge clk) begin
		if (take) begin
			drain_q    <= cur_drain;
			last_col_q <= cur_last;
			produce_q  <= (row_q != '0);
			top_mid_q  <= (row_q == RW'(1));
			c_q        <= cur_c;
			px_q       <= {pixel.in_red, pixel.in_green, pixel.in_blue};
		end
	end

	// line stores: upper row in the high half, middle row in the low half
	logic [47:0] rd_data;
	logic        wr_en;
	logic [23:0] mid_px, top_px, bot_px;

	sem_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW),
		.DW    (48)
	) u_line (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (c_q),
		.wr_data ({mid_px, px_q}),
		.rd_addr (cur_c),
		.rd_data (rd_data)
	);

	assign mid_px = rd_data[23:0];
	assign top_px = top_mid_q ? mid_px : rd_data[47:24];
	assign bot_px = drain_q ? mid_px : px_q;

	// sequencer
	logic adv;
	logic do_load, do_shift, push, push_last, push_fend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (take) state_nxt = S_LOAD;
			S_LOAD:  state_nxt = S_EMIT1;
			S_EMIT1: begin
				if (adv || !(produce_q && c_q != '0)) begin
					state_nxt = last_col_q ? S_EMIT2 : S_IDLE;
				end
			end
			S_EMIT2: if (adv || !produce_q) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		pixel_stall = 1'b1;
		do_load     = 1'b0;
		do_shift    = 1'b0;
		push        = 1'b0;
		push_last   = 1'b0;
		push_fend   = 1'b0;
		case (state_q)
			S_IDLE:  pixel_stall = 1'b0;
			S_LOAD:  do_load = 1'b1;
			S_EMIT1: begin
				push      = adv && produce_q && (c_q != '0);
				push_last = !(last_col_q && produce_q);
				do_shift  = last_col_q && (adv || !(produce_q && c_q != '0));
			end
			S_EMIT2: begin
				push      = adv && produce_q;
				push_last = 1'b1;
				push_fend = drain_q;
			end
			default: ;
		endcase
	end

	assign wr_en = do_load && !drain_q;

	// 3x3 window, entries 0..2 top row, 6..8 bottom row, right column newest
	logic [8:0][23:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (do_load && c_q == '0) begin
			win_q <= {{3{bot_px}}, {3{mid_px}}, {3{top_px}}};
		end else if (do_load || do_shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3+0] <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			if (do_load) begin
				win_q[2] <= top_px;
				win_q[5] <= mid_px;
				win_q[8] <= bot_px;
			end
		end
	end

	// advance the whole result pipe unless the output register is blocked
	logic    out_v_q;
	result_t out_q;

	assign adv = !(out_v_q && result_stall);

	// gradient stage
	grad_t g_nxt, g_s1;
	logic  v_s1;

	always_comb begin
		logic [9:0] xr, xl, yb, yt;
		g_nxt = '0;
		for (int k = 0; k < 3; k++) begin
			xr = tap_sum(win_q[2][k*8+:8], win_q[5][k*8+:8], win_q[8][k*8+:8]);
			xl = tap_sum(win_q[0][k*8+:8], win_q[3][k*8+:8], win_q[6][k*8+:8]);
			yb = tap_sum(win_q[6][k*8+:8], win_q[7][k*8+:8], win_q[8][k*8+:8]);
			yt = tap_sum(win_q[0][k*8+:8], win_q[1][k*8+:8], win_q[2][k*8+:8]);
			g_nxt.ax[k] = abs_diff(xr, xl);
			g_nxt.ay[k] = abs_diff(yb, yt);
		end
		g_nxt.mode = mm_q;
		g_nxt.last = push_last;
		g_nxt.fend = push_fend;
	end

	// square and halved-sum stage
	sq_beat_t sq_nxt;
	sq_beat_t chain_beat [9];
	logic     chain_v    [9];

	always_comb begin
		logic [20:0] sq;
		logic [10:0] l1s;
		sq_nxt = '0;
		for (int k = 0; k < 3; k++) begin
			sq  = 21'(g_s1.ax[k]) * 21'(g_s1.ax[k]) + 21'(g_s1.ay[k]) * 21'(g_s1.ay[k]);
			l1s = {1'b0, g_s1.ax[k]} + {1'b0, g_s1.ay[k]};
			sq_nxt.ch[k].sat  = |sq[20:16];
			sq_nxt.ch[k].rad  = sq[15:0];
			sq_nxt.ch[k].root = '0;
			sq_nxt.ch[k].l1   = (|l1s[10:9]) ? MAG_CLAMP : l1s[8:1];
		end
		sq_nxt.mode = g_s1.mode;
		sq_nxt.last = g_s1.last;
		sq_nxt.fend = g_s1.fend;
	end

	logic     v_s2;
	sq_beat_t b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1 <= g_nxt;
			b_s2 <= sq_nxt;
		end
	end

	assign chain_v[0]    = v_s2;
	assign chain_beat[0] = b_s2;

	// one root bit per cell, most significant first
	for (genvar i = 0; i < 8; i++) begin : g_root
		sem_sqrt_cell #(
			.BIT (7 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_v     (chain_v[i]),
			.in_beat  (chain_beat[i]),
			.out_v    (chain_v[i+1]),
			.out_beat (chain_beat[i+1])
		);
	end

	// pick the magnitude per mode and register the result beat
	result_t res_nxt;
	logic [2:0][7:0] mag;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (chain_beat[8].mode) begin
				mag[k] = chain_beat[8].ch[k].l1;
			end else begin
				mag[k] = chain_beat[8].ch[k].sat ? MAG_CLAMP : chain_beat[8].ch[k].root;
			end
		end
		res_nxt.edge_red   = mag[2];
		res_nxt.edge_green = mag[1];
		res_nxt.edge_blue  = mag[0];
		res_nxt.last       = chain_beat[8].last;
		res_nxt.frame_end  = chain_beat[8].fend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= chain_v[8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_nxt;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	// checks
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_end |-> result.last)
		else $error("frame_end without last");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(col_q) < MAXW_C && CMPW'(drn_q) < MAXW_C)
		else $error("column counter out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(row_q) <= MAXH_C)
		else $error("row counter out of range");

	a_take_load: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q == S_LOAD)
		else $error("accepted beat not loaded");

	a_push_adv: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> adv && (state_q == S_EMIT1 || state_q == S_EMIT2))
		else $error("push outside emit while blocked");

endmodule

`default_nettype wire

// ===== hdl/sem_line_mem.sv =====
// ----------------------------------------------------------------------------
// Sobel line store
// Single-port-write, registered-read memory holding the two previous rows.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_line_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 48
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/sem_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Sobel root cell
// Decide one bit of the integer square root for all three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_sqrt_cell
	import sem_pkg::*;
#(
	parameter int BIT = 7
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire logic     in_v,
	input  wire sq_beat_t in_beat,
	output logic          out_v,
	output sq_beat_t      out_beat
);

	localparam logic [7:0] TRIAL_BIT = 8'(1 << BIT);

	logic     v_q;
	sq_beat_t beat_q;
	sq_beat_t nxt;

	always_comb begin
		logic [7:0]  t;
		logic [15:0] tt;
		nxt = in_beat;
		for (int k = 0; k < 3; k++) begin
			t  = in_beat.ch[k].root | TRIAL_BIT;
			tt = 16'(t) * 16'(t);
			if (tt <= in_beat.ch[k].rad) begin
				nxt.ch[k].root = t;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_q <= nxt;
		end
	end

	assign out_v    = v_q;
	assign out_beat = beat_q;

endmodule

`default_nettype wire
